// ===== sv/ltd_pkg.sv =====
// Shared types and constants of the LZ77 triple decoder.
`default_nettype none
package ltd_pkg;

    localparam int OFFSET_W  = 16;
    localparam int LENGTH_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int EXT_W     = OFFSET_W + 1;
    localparam int S_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic emit_copy;
        logic emit_lit;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic will_copy;
        logic last_copy;
        logic out_free;
    } t_ctl_sts;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_LIT  = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// ===== sv/ltd_ctrl.sv =====
// Controller state machine: sequences the copy bytes and the literal of one triple.
`default_nettype none
module ltd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire ltd_pkg::t_ctl_sts i_sts,
    output ltd_pkg::t_ctl_cmd      o_cmd
);

    ltd_pkg::t_state r_state;
    ltd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ltd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.will_copy ? ltd_pkg::ST_READ : ltd_pkg::ST_LIT;
                end
            end
            ltd_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ltd_pkg::ST_EMIT;
            end
            ltd_pkg::ST_EMIT: begin
                // hold the read word until the output register can take it
                if (i_sts.out_free) begin
                    o_cmd.emit_copy = 1'b1;
                    n_state = i_sts.last_copy ? ltd_pkg::ST_LIT : ltd_pkg::ST_READ;
                end
            end
            ltd_pkg::ST_LIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_lit = 1'b1;
                    n_state        = ltd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ltd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/ltd_datapath.sv =====
// Datapath: history window, pointers, triple registers and output register.
`default_nettype none
module ltd_datapath #(
    parameter int WINDOW_DEPTH = 65536,
    parameter int MAX_MATCH    = 63
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ltd_pkg::OFFSET_W-1:0]  i_match_offset,
    input  wire logic [ltd_pkg::LENGTH_W-1:0]  i_match_length,
    input  wire logic [ltd_pkg::BYTE_W-1:0]    i_literal_byte,
    input  wire ltd_pkg::t_ctl_cmd             i_cmd,
    output ltd_pkg::t_ctl_sts                  o_sts,
    input  wire logic                          i_m_tready,
    output logic                               o_out_valid,
    output logic [ltd_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_out_last,
    output logic                               o_out_bad,
    output logic                               o_out_clip
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = AW + 1;
    localparam int LEN_W = $clog2(MAX_MATCH + 1);

    logic [ltd_pkg::BYTE_W-1:0] r_window [WINDOW_DEPTH];
    logic [ltd_pkg::BYTE_W-1:0] r_rd_data;

    logic [AW-1:0]              r_wp;
    logic [CNT_W-1:0]           r_cnt;
    logic [AW-1:0]              r_pos;
    logic [LEN_W-1:0]           r_remain;
    logic [ltd_pkg::BYTE_W-1:0] r_lit;
    logic                       r_bad;
    logic                       r_clip;

    logic                       r_out_valid;
    logic [ltd_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;
    logic                       r_out_bad;
    logic                       r_out_clip;

    logic                       clip;
    logic [LEN_W-1:0]           eff_len;
    logic                       len_nz;
    logic                       off_ok;
    logic [ltd_pkg::EXT_W-1:0]  wp_x;
    logic [ltd_pkg::EXT_W-1:0]  off_x;
    logic [ltd_pkg::EXT_W-1:0]  pos_x;
    logic                       push;
    logic [ltd_pkg::BYTE_W-1:0] push_byte;

    // Triple decode.
    always_comb begin
        clip    = i_match_length > ltd_pkg::LENGTH_W'(MAX_MATCH);
        eff_len = clip ? LEN_W'(MAX_MATCH) : i_match_length[LEN_W-1:0];
        len_nz  = i_match_length != '0;
        wp_x    = ltd_pkg::EXT_W'(r_wp);
        off_x   = ltd_pkg::EXT_W'(i_match_offset);
        off_ok  = (i_match_offset != '0) && (off_x <= ltd_pkg::EXT_W'(r_cnt));
        pos_x   = (wp_x >= off_x) ? (wp_x - off_x)
                                  : (wp_x + ltd_pkg::EXT_W'(WINDOW_DEPTH) - off_x);
    end

    assign push      = i_cmd.emit_copy | i_cmd.emit_lit;
    assign push_byte = i_cmd.emit_copy ? r_rd_data : r_lit;

    assign o_sts.will_copy = len_nz & off_ok;
    assign o_sts.last_copy = r_remain == LEN_W'(1);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // Window memory: one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_window[r_wp] <= push_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_window[r_pos];
        end
    end

    // Write pointer and saturating fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (push) begin
            r_wp <= (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_cnt != CNT_W'(WINDOW_DEPTH)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Triple registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos    <= pos_x[AW-1:0];
            r_remain <= eff_len;
            r_lit    <= i_literal_byte;
            r_bad    <= len_nz & ~off_ok;
            r_clip   <= clip;
        end else begin
            if (i_cmd.rd) begin
                r_pos <= (r_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
            end
            if (i_cmd.emit_copy) begin
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_byte <= push_byte;
            r_out_last <= i_cmd.emit_lit;
            r_out_bad  <= r_bad;
            r_out_clip <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_bad   = r_out_bad;
    assign o_out_clip  = r_out_clip;

endmodule
`default_nettype wire

// ===== sv/lz77_triple_decoder.sv =====
// LZ77 triple decoder: (offset, length, literal) triples in, decompressed bytes out.
//
// Input stream: one triple per word. tdata packs match_offset [15:0],
// match_length [31:16] and literal_byte [39:32].
// Output stream: one byte per word in tdata[7:0]; tlast marks the literal that
// ends a triple; tuser[0] is bad_offset, tuser[1] is length_clipped, both held
// on every byte of the triple.
// A triple whose copy of L bytes (L clipped to MAX_MATCH) is valid gives the L
// copied bytes and then the literal; a triple without a copy gives only the
// literal. Each copied byte is read from the window, then written back to the
// history memory and emitted. The first byte of a triple passes through the LIT
// state, or the READ and EMIT states for a copy, before the output register.
// Reset clears the write pointer, the fill count and the output valid flag; the
// window contents are not cleared, and valid offsets never reach unwritten
// entries. When the receiver stalls, the current byte holds in the output
// register and the decoder waits; tready on the input is high only between
// triples.
`default_nettype none
module lz77_triple_decoder #(
    parameter int WINDOW_DEPTH = 65536,
    parameter int MAX_MATCH    = 63
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // match_offset [15:0], match_length [31:16], literal_byte [39:32]
    input  wire logic [ltd_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // out_byte [7:0]
    output logic [ltd_pkg::BYTE_W-1:0]           o_m_tdata,
    output logic                                 o_m_tlast,
    // bad_offset [0], length_clipped [1]
    output logic [ltd_pkg::M_TUSER_W-1:0]        o_m_tuser
);

    ltd_pkg::t_ctl_cmd cmd;
    ltd_pkg::t_ctl_sts sts;
    logic              out_bad;
    logic              out_clip;

    ltd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ltd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_match_offset (i_s_tdata[15:0]),
        .i_match_length (i_s_tdata[31:16]),
        .i_literal_byte (i_s_tdata[39:32]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_m_tready     (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_out_byte     (o_m_tdata),
        .o_out_last     (o_m_tlast),
        .o_out_bad      (out_bad),
        .o_out_clip     (out_clip)
    );

    assign o_m_tuser = {out_clip, out_bad};

endmodule
`default_nettype wire

// ===== sv/ltd_checker.sv =====
// Port-level checker for the LZ77 triple decoder, bound to the top level.
`default_nettype none
module ltd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [ltd_pkg::BYTE_W-1:0]    o_m_tdata,
    input wire logic                          o_m_tlast,
    input wire logic [ltd_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    // No word is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A bad offset skips the copy, so only the literal carries the flag.
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("bad offset flag on a copied byte");

    // A triple is taken only between triples.
    a_one_triple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after accepting a triple");

endmodule

bind lz77_triple_decoder ltd_checker u_ltd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

// ===== dv/lz77_triple_decoder_chk.sv =====
// Scoreboard for the LZ77 triple decoder: predicts output bytes and checks them.
module lz77_triple_decoder_chk #(
    parameter int WINDOW_DEPTH = 65536,
    parameter int MAX_MATCH    = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // match_offset [15:0], match_length [31:16], literal_byte [39:32]
    input  logic [ltd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // out_byte [7:0]
    input  logic [ltd_pkg::BYTE_W-1:0]        i_m_tdata,
    input  logic                              i_m_tlast,
    // bad_offset [0], length_clipped [1]
    input  logic [ltd_pkg::M_TUSER_W-1:0]     i_m_tuser,
    output int                                o_fail_cnt,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ltd_pkg::BYTE_W-1:0] data;
        logic                       last;
        logic                       bad;
        logic                       clip;
    } t_out_word;

    t_out_word                  expected_bytes[$];
    logic [ltd_pkg::BYTE_W-1:0] history [0:WINDOW_DEPTH-1];
    logic [ltd_pkg::OFFSET_W-1:0] wr_ptr;
    int unsigned                fill_cnt;
    int                         mismatches;

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
        mismatches = 0;
        wr_ptr     = '0;
        fill_cnt   = 0;
    end

    task automatic append_byte(input logic [ltd_pkg::BYTE_W-1:0] b);
        history[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (fill_cnt < WINDOW_DEPTH)
            fill_cnt++;
    endtask

    task automatic decode_triple(input logic [ltd_pkg::S_TDATA_W-1:0] word);
        logic [ltd_pkg::OFFSET_W-1:0] offset;
        logic [ltd_pkg::LENGTH_W-1:0] run_len;
        logic [ltd_pkg::OFFSET_W-1:0] src;
        logic [ltd_pkg::BYTE_W-1:0]   lit;
        logic [ltd_pkg::BYTE_W-1:0]   b;
        logic                         bad;
        logic                         clip;
        int                           j;
        offset  = word[15:0];
        run_len = word[31:16];
        lit     = word[39:32];
        clip    = run_len > MAX_MATCH;
        if (clip)
            run_len = ltd_pkg::LENGTH_W'(MAX_MATCH);
        bad = (run_len != 0) && (offset == 0 || offset > fill_cnt);
        if (run_len != 0 && !bad) begin
            // pointer width equals the window, so the subtraction wraps by itself
            src = wr_ptr - offset;
            for (j = 0; j < run_len; j++) begin
                b = history[src];
                expected_bytes.insert(expected_bytes.size(),
                                      t_out_word'{b, 1'b0, 1'b0, clip});
                append_byte(b);
                src = src + 1'b1;
            end
        end
        expected_bytes.insert(expected_bytes.size(), t_out_word'{lit, 1'b1, bad, clip});
        append_byte(lit);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            expected_bytes.delete();
            wr_ptr   = '0;
            fill_cnt = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                decode_triple(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata, i_m_tlast, i_m_tuser[0], i_m_tuser[1]};
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: byte=%02h last=%b bad=%b clip=%b",
                             $time, got.data, got.last, got.bad, got.clip);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.bad !== want.bad || got.clip !== want.clip) begin
                        mismatches++;
                        // flags listed as last, bad, clip
                        $display("%0t: expected byte=%02h flags=%b%b%b, got byte=%02h flags=%b%b%b",
                                 $time, want.data, want.last, want.bad, want.clip,
                                 got.data, got.last, got.bad, got.clip);
                    end
                end
            end
        end
        o_pending  <= expected_bytes.size();
        o_fail_cnt <= mismatches;
    end

endmodule

// ===== dv/lz77_triple_decoder_tb.sv =====
// Testbench top for the LZ77 triple decoder: clock, reset, triple stimulus and verdict.
module lz77_triple_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WINDOW_DEPTH = 65536;
    localparam int          MAX_MATCH    = 63;
    localparam int          MAX_OFFSET   = 65535;
    localparam longint      CYCLE_LIMIT  = 3_000_000;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              s_tvalid   = 1'b0;
    logic                              s_tready;
    // match_offset [15:0], match_length [31:16], literal_byte [39:32]
    logic [ltd_pkg::S_TDATA_W-1:0]     s_tdata    = '0;
    logic                              m_tvalid;
    logic                              m_tready   = 1'b0;
    // out_byte [7:0]
    logic [ltd_pkg::BYTE_W-1:0]        m_tdata;
    logic                              m_tlast;
    // bad_offset [0], length_clipped [1]
    logic [ltd_pkg::M_TUSER_W-1:0]     m_tuser;

    int          fail_cnt;
    int          pending;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    // bytes the decoder has produced so far, saturating at the window depth
    int unsigned produced  = 0;
    longint      cycle_cnt = 0;

    lz77_triple_decoder #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    lz77_triple_decoder_chk #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tlast  (m_tlast),
        .i_m_tuser  (m_tuser),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_triple(input logic [15:0] offset, input logic [15:0] run_len,
                               input logic [7:0] lit);
        int unsigned copied;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lit, run_len, offset};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        copied = (run_len > MAX_MATCH) ? MAX_MATCH : run_len;
        if (copied != 0 && offset != 0 && offset <= produced)
            produced += copied;
        produced += 1;
        if (produced > WINDOW_DEPTH)
            produced = WINDOW_DEPTH;
    endtask

    // Hold the sender until every predicted word has been drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic send_random();
        int unsigned span;
        int unsigned pick;
        logic [15:0] offset;
        logic [15:0] run_len;
        span = (produced > MAX_OFFSET) ? MAX_OFFSET : produced;
        pick = $urandom_range(99);
        if (pick < 10)
            run_len = '0;
        else if (pick < 70)
            run_len = 16'($urandom_range(16, 1));
        else if (pick < 85)
            run_len = 16'($urandom_range(MAX_MATCH, 17));
        else if (pick < 95)
            run_len = 16'($urandom_range(65535, MAX_MATCH + 1));
        else
            run_len = 16'hFFFF;
        pick = $urandom_range(99);
        if (span == 0 || pick >= 85) begin
            // broken offset: zero, or past the bytes written so far
            if (span < MAX_OFFSET && pick[0])
                offset = 16'($urandom_range(MAX_OFFSET, span + 1));
            else
                offset = '0;
        end else if (pick < 45) begin
            offset = 16'($urandom_range((span < 4) ? span : 4, 1));
        end else begin
            offset = 16'($urandom_range(span, 1));
        end
        send_triple(offset, run_len, 8'($urandom_range(255)));
    endtask

    task automatic random_phase(input int unsigned gap, input int unsigned stall,
                                input int n);
        int k;
        gap_pct   = gap;
        stall_pct = stall;
        for (k = 0; k < n; k++)
            send_random();
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero length, bad offsets, overlap, clipping, oldest byte
        send_triple(16'd0, 16'd0, 8'h00);
        send_triple(16'd0, 16'd5, 8'hFF);
        send_triple(16'd1, 16'd0, 8'hA5);
        send_triple(16'd5, 16'd3, 8'h11);
        send_triple(16'd1, 16'd10, 8'h22);
        send_triple(16'd4, 16'd4, 8'h33);
        send_triple(16'd0, 16'hFFFF, 8'h44);
        send_triple(16'hFFFF, 16'd100, 8'h55);
        send_triple(16'd2, 16'd64, 8'h66);
        send_triple(16'd1, 16'd63, 8'h77);
        send_triple(16'd3, 16'd1, 8'h88);
        send_triple(produced[15:0], 16'd20, 8'h99);
        send_triple(produced[15:0] + 16'd1, 16'd1, 8'hAA);
        send_triple(16'd7, 16'hFFFF, 8'hFF);
        drain();

        random_phase(0, 0, 80);
        random_phase(51, 0, 80);
        random_phase(0, 51, 80);
        random_phase(19, 19, 80);

        // offsets at the far end of the window
        send_triple(16'hFFFF, 16'd63, 8'h5A);
        send_triple(16'hFFFF, 16'd1, 8'hC3);
        random_phase(19, 19, 25);

        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
